/* hdl/pdr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pdr_pkg: shared types and constants of the pairwise distance unit
// Transaction payloads, configuration register indexes, result kinds and the
// fixed arithmetic widths of the distance datapath.
// ----------------------------------------------------------------------------
package pdr_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned COORD_FIELD_W = 16;
  localparam int unsigned IDX_OUT_W     = 3;
  localparam int unsigned DIST_W        = 17;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTICLES_IN_USE = 1'b1;
  localparam logic [1:0] DIMS_RESET  = 2'd3;
  localparam logic [3:0] PARTS_RESET = 4'd8;

  // Result kinds.
  localparam logic KIND_RADIAL = 1'b0;
  localparam logic KIND_PAIR   = 1'b1;

  // Datapath widths. A coordinate difference is clamped at 2^17, which
  // already forces a saturated distance, so the magnitude needs 18 bits.
  localparam int unsigned DIFF_CAP = 32'd131072;
  localparam int unsigned MAG_W    = 18;
  localparam int unsigned SQ_W     = 2 * MAG_W;
  localparam int unsigned SUM_W    = SQ_W + 2;
  localparam int unsigned RAD_W    = 2 * DIST_W;
  localparam int unsigned ROOT_W   = DIST_W;
  localparam int unsigned REM_W    = ROOT_W + 1;

  typedef struct packed {
    logic signed [COORD_FIELD_W-1:0] coord_x;
    logic signed [COORD_FIELD_W-1:0] coord_y;
    logic signed [COORD_FIELD_W-1:0] coord_z;
    logic                            new_set;
  } in_t;

  typedef struct packed {
    logic                 kind;
    logic [IDX_OUT_W-1:0] first_index;
    logic [IDX_OUT_W-1:0] second_index;
    logic [DIST_W-1:0]    distance;
    logic                 last;
  } out_t;

  // Result identity that travels alongside the datapath.
  typedef struct packed {
    logic                 kind;
    logic [IDX_OUT_W-1:0] first_index;
    logic [IDX_OUT_W-1:0] second_index;
    logic                 last;
  } tag_t;

  typedef struct packed {
    logic valid;
    tag_t tag;
  } ctl_t;

endpackage
`default_nettype wire

/* hdl/pdr_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pdr_lane: one coordinate lane
// Takes the difference of two coordinates, its clamped magnitude, and its
// square, with a register after the magnitude and after the square.
// ----------------------------------------------------------------------------
module pdr_lane #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic                         active_i,
  input  logic signed [COORD_WIDTH-1:0] a_i,
  input  logic signed [COORD_WIDTH-1:0] b_i,
  output logic [pdr_pkg::SQ_W-1:0]     sq_o
);
  import pdr_pkg::*;

  localparam int unsigned FULL_W = COORD_WIDTH + 1;

  logic signed [FULL_W-1:0] diff;
  logic [FULL_W-1:0]        mag_full;
  logic [MAG_W-1:0]         mag_d;
  logic [MAG_W-1:0]         mag_q;
  logic [SQ_W-1:0]          sq_q;

  // Absolute difference, clamped; an unused dimension contributes nothing.
  always_comb begin
    diff     = FULL_W'(a_i) - FULL_W'(b_i);
    mag_full = diff[FULL_W-1] ? (~diff + 1'b1) : diff;
    if (!active_i) begin
      mag_d = '0;
    end else if (34'(mag_full) > 34'(DIFF_CAP)) begin
      mag_d = MAG_W'(DIFF_CAP);
    end else begin
      mag_d = MAG_W'(mag_full);
    end
  end

  // Magnitude stage, then square stage.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      sq_q  <= SQ_W'(mag_q) * SQ_W'(mag_q);
    end
  end

  assign sq_o = sq_q;

endmodule
`default_nettype wire

/* hdl/pdr_merge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pdr_merge: lane merge stage
// Adds the squared differences of all lanes and flags sums whose root would
// exceed the distance range.
// ----------------------------------------------------------------------------
module pdr_merge #(
  parameter int unsigned MAX_DIMENSIONS = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [pdr_pkg::SQ_W-1:0]   sq_i [MAX_DIMENSIONS],
  input  pdr_pkg::ctl_t              ctl_i,
  output pdr_pkg::ctl_t              ctl_o,
  output logic [pdr_pkg::RAD_W-1:0]  rad_o,
  output logic                       sat_o
);
  import pdr_pkg::*;

  logic [SUM_W-1:0] sum;
  ctl_t             ctl_q;
  logic [RAD_W-1:0] rad_q;
  logic             sat_q;

  // Sum of squares over the lanes.
  always_comb begin
    sum = '0;
    for (int l = 0; l < MAX_DIMENSIONS; l++) begin
      sum = sum + SUM_W'(sq_i[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  // A sum of 2^34 or more has a root beyond the 17-bit range.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q <= sum[RAD_W-1:0];
      sat_q <= |sum[SUM_W-1:RAD_W];
    end
  end

  assign ctl_o = ctl_q;
  assign rad_o = rad_q;
  assign sat_o = sat_q;

endmodule
`default_nettype wire

/* hdl/pdr_sqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pdr_sqrt: pipelined floored square root
// One result bit per stage, most significant first, by the digit-by-digit
// method on two radicand bits at a time.
// ----------------------------------------------------------------------------
module pdr_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  pdr_pkg::ctl_t               ctl_i,
  input  logic [pdr_pkg::RAD_W-1:0]   rad_i,
  input  logic                        sat_i,
  output pdr_pkg::ctl_t               ctl_o,
  output logic [pdr_pkg::ROOT_W-1:0]  root_o,
  output logic                        sat_o
);
  import pdr_pkg::*;

  localparam int unsigned SH_W = REM_W + 2;

  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic              sat_q  [ROOT_W];
  ctl_t              ctl_q  [ROOT_W];

  logic [REM_W-1:0]  rem_d  [ROOT_W];
  logic [ROOT_W-1:0] root_d [ROOT_W];
  logic [RAD_W-1:0]  rad_d  [ROOT_W];

  // Each stage tries to set the next root bit against the partial remainder.
  always_comb begin
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [RAD_W-1:0]  rad_p;
    logic [SH_W-1:0]   rem_sh;
    logic [SH_W-1:0]   trial;
    logic              take;
    for (int s = 0; s < ROOT_W; s++) begin
      if (s == 0) begin
        rem_p  = '0;
        root_p = '0;
        rad_p  = rad_i;
      end else begin
        rem_p  = rem_q[s-1];
        root_p = root_q[s-1];
        rad_p  = rad_q[s-1];
      end
      rem_sh    = {rem_p, rad_p[RAD_W-1 -: 2]};
      trial     = {1'b0, root_p, 2'b01};
      take      = (rem_sh >= trial);
      rem_d[s]  = take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_d[s] = {root_p[ROOT_W-2:0], take};
      rad_d[s]  = {rad_p[RAD_W-3:0], 2'b00};
    end
  end

  // Control travels with its data through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < ROOT_W; s++) begin
        ctl_q[s] <= '0;
      end
    end else if (en_i) begin
      for (int s = 0; s < ROOT_W; s++) begin
        ctl_q[s] <= (s == 0) ? ctl_i : ctl_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < ROOT_W; s++) begin
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
        rad_q[s]  <= rad_d[s];
        sat_q[s]  <= (s == 0) ? sat_i : sat_q[s-1];
      end
    end
  end

  assign ctl_o  = ctl_q[ROOT_W-1];
  assign root_o = root_q[ROOT_W-1];
  assign sat_o  = sat_q[ROOT_W-1];

endmodule
`default_nettype wire

/* hdl/pairwise_distance_and_radius_unit.sv */
`default_nettype none
// The first result of an item passes the issue, lane, merge, square root and
// output registers. An item with particle index k yields k+1 results, issued
// one after another through the single read port of the position store. The
// next item is accepted in the cycle that issues the current item's last
// result. Reset clears the set counter and all valid flags and returns the
// registers to three dimensions and eight particles; the position store
// holds no reset value and needs none.
// ----------------------------------------------------------------------------
// pairwise_distance_and_radius_unit: particle distance matrix generator
// Stores each particle position and emits its radial distance followed by
// its distances to all earlier particles of the set, through parallel
// coordinate lanes, a merge adder and a pipelined square root.
// ----------------------------------------------------------------------------
module pairwise_distance_and_radius_unit #(
  parameter int unsigned MAX_PARTICLES  = 8,
  parameter int unsigned MAX_DIMENSIONS = 3,
  parameter int unsigned COORD_WIDTH    = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pdr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  pdr_pkg::in_t                     in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output pdr_pkg::out_t                    out_o
);
  import pdr_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_PARTICLES);
  localparam int unsigned CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned POS_W = MAX_DIMENSIONS * COORD_WIDTH;

  // Configuration and sequencing state.
  logic [1:0]       dims_q;
  logic [3:0]       parts_q;
  logic [IDX_W-1:0] count_q;
  logic             busy_q;
  logic [IDX_W-1:0] k_q;
  logic [IDX_W-1:0] n_q;
  logic [POS_W-1:0] cur_q;

  // Position store and issue stage.
  logic [POS_W-1:0] mem_q [MAX_PARTICLES];
  logic [POS_W-1:0] rd_q;
  logic [POS_W-1:0] s1_cur_q;
  ctl_t             s1_ctl_q;
  ctl_t             la_ctl_q;
  ctl_t             lb_ctl_q;

  // Output register.
  logic out_valid_q;
  out_t out_q;

  logic [1:0]                 nd;
  logic [CNT_W-1:0]           np;
  logic [MAX_DIMENSIONS-1:0]  active;
  logic [COORD_FIELD_W-1:0]   fld [3];
  logic [POS_W-1:0]           pos_new;
  logic [IDX_W-1:0]           cnt_sel;
  logic [IDX_W-1:0]           k_new;
  logic [CNT_W-1:0]           k_inc;
  logic [IDX_W-1:0]           count_d;
  logic                       adv;
  logic                       issue;
  logic                       last_op;
  logic                       in_accept;
  logic [IDX_W-1:0]           n_m1;
  logic [IDX_W-1:0]           rd_addr;
  tag_t                       issue_tag;
  logic [SQ_W-1:0]            sq [MAX_DIMENSIONS];
  ctl_t                       mg_ctl;
  logic [RAD_W-1:0]           mg_rad;
  logic                       mg_sat;
  ctl_t                       sr_ctl;
  logic [ROOT_W-1:0]          sr_root;
  logic                       sr_sat;

  // Effective dimension and particle counts, with out-of-range values
  // pulled into range.
  always_comb begin
    if (dims_q == 2'd0) begin
      nd = 2'd1;
    end else if (32'(dims_q) > MAX_DIMENSIONS) begin
      nd = 2'(MAX_DIMENSIONS);
    end else begin
      nd = dims_q;
    end
    if (parts_q == 4'd0) begin
      np = CNT_W'(1);
    end else if (32'(parts_q) > MAX_PARTICLES) begin
      np = CNT_W'(MAX_PARTICLES);
    end else begin
      np = CNT_W'(parts_q);
    end
    for (int l = 0; l < MAX_DIMENSIONS; l++) begin
      active[l] = (32'(l) < 32'(nd));
    end
  end

  // Incoming coordinates, taken from the low COORD_WIDTH bits of each field.
  always_comb begin
    logic [31:0] raw;
    fld[0] = in_i.coord_x;
    fld[1] = in_i.coord_y;
    fld[2] = in_i.coord_z;
    for (int l = 0; l < MAX_DIMENSIONS; l++) begin
      raw = 32'(fld[l]);
      pos_new[l*COORD_WIDTH +: COORD_WIDTH] = raw[COORD_WIDTH-1:0];
    end
  end

  // Index of the arriving particle and the counter's next value.
  always_comb begin
    cnt_sel = in_i.new_set ? '0 : count_q;
    k_new   = (CNT_W'(cnt_sel) >= np) ? '0 : cnt_sel;
    k_inc   = CNT_W'(k_new) + CNT_W'(1);
    count_d = (k_inc >= np) ? '0 : IDX_W'(k_inc);
  end

  // Issue control: one result per cycle while busy and the pipeline moves.
  assign adv        = !out_valid_q || out_ready_i;
  assign last_op    = (n_q == k_q);
  assign issue      = busy_q && adv;
  assign in_ready_o = !busy_q || (adv && last_op);
  assign in_accept  = in_valid_i && in_ready_o;
  assign n_m1       = n_q - IDX_W'(1);
  assign rd_addr    = (n_q == '0) ? '0 : n_m1;

  always_comb begin
    issue_tag.kind         = (n_q == '0) ? KIND_RADIAL : KIND_PAIR;
    issue_tag.first_index  = (n_q == '0) ? IDX_OUT_W'(k_q) : IDX_OUT_W'(n_m1);
    issue_tag.second_index = IDX_OUT_W'(k_q);
    issue_tag.last         = last_op;
  end

  // Configuration registers and the result sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q  <= DIMS_RESET;
      parts_q <= PARTS_RESET;
      count_q <= '0;
      busy_q  <= 1'b0;
      k_q     <= '0;
      n_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DIMS_IN_USE:      dims_q  <= cfg_data_i[1:0];
          REG_PARTICLES_IN_USE: parts_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_accept) begin
        busy_q  <= 1'b1;
        n_q     <= '0;
        k_q     <= k_new;
        count_q <= count_d;
      end else if (issue) begin
        if (last_op) begin
          busy_q <= 1'b0;
        end else begin
          n_q <= n_q + IDX_W'(1);
        end
      end
    end
  end

  // Position of the particle being processed.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cur_q <= pos_new;
    end
  end

  // Position store: written on acceptance, read whenever the pipeline advances.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mem_q[k_new] <= pos_new;
    end
    if (adv) begin
      rd_q     <= mem_q[rd_addr];
      s1_cur_q <= cur_q;
    end
  end

  // Control pipeline alongside the lane stages, and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q    <= '0;
      la_ctl_q    <= '0;
      lb_ctl_q    <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_ctl_q.valid <= busy_q;
      s1_ctl_q.tag   <= issue_tag;
      la_ctl_q       <= s1_ctl_q;
      lb_ctl_q       <= la_ctl_q;
      out_valid_q    <= sr_ctl.valid;
    end
  end

  // Coordinate lanes; the radial result measures against the origin.
  for (genvar l = 0; l < MAX_DIMENSIONS; l++) begin : g_lane
    logic signed [COORD_WIDTH-1:0] other;
    assign other = (s1_ctl_q.tag.kind == KIND_RADIAL) ? '0 :
                   rd_q[l*COORD_WIDTH +: COORD_WIDTH];
    pdr_lane #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_lane (
      .clk_i   (clk_i),
      .en_i    (adv),
      .active_i(active[l]),
      .a_i     (s1_cur_q[l*COORD_WIDTH +: COORD_WIDTH]),
      .b_i     (other),
      .sq_o    (sq[l])
    );
  end

  pdr_merge #(
    .MAX_DIMENSIONS(MAX_DIMENSIONS)
  ) u_merge (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .sq_i  (sq),
    .ctl_i (lb_ctl_q),
    .ctl_o (mg_ctl),
    .rad_o (mg_rad),
    .sat_o (mg_sat)
  );

  pdr_sqrt u_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .ctl_i (mg_ctl),
    .rad_i (mg_rad),
    .sat_i (mg_sat),
    .ctl_o (sr_ctl),
    .root_o(sr_root),
    .sat_o (sr_sat)
  );

  // Output register; saturated sums give the largest distance.
  always_ff @(posedge clk_i) begin
    if (adv && sr_ctl.valid) begin
      out_q.kind         <= sr_ctl.tag.kind;
      out_q.first_index  <= sr_ctl.tag.first_index;
      out_q.second_index <= sr_ctl.tag.second_index;
      out_q.distance     <= sr_sat ? '1 : sr_root;
      out_q.last         <= sr_ctl.tag.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The result counter never runs past the particle index.
  a_op_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (n_q <= k_q))
    else $error("result counter beyond particle index");

  // An accepted transaction always starts with its radial result.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (busy_q && (n_q == '0)))
    else $error("accepted transaction did not start at the radial result");

  // A radial result names the new particle in both index fields.
  a_radial_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.kind == KIND_RADIAL)) |->
      (out_q.first_index == out_q.second_index))
    else $error("radial result with mismatched indexes");

endmodule
`default_nettype wire

/* sim/pairwise_distance_and_radius_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_distance_and_radius_unit_tb: self-checking bench for the distance
// matrix generator
// Drives particle positions through the input handshake, predicts the radial
// and pair distances of every accepted particle, and compares each result
// leaving the output handshake field by field. Directed phases cover the
// coordinate extremes and the register corner cases. Random phases follow
// with random idling on both sides, one long output stall and a drain
// before every register write.
// ----------------------------------------------------------------------------
module pairwise_distance_and_radius_unit_tb;
  import pdr_pkg::*;

  localparam int unsigned MAX_PARTICLES  = 8;
  localparam int unsigned MAX_DIMENSIONS = 3;
  localparam int unsigned DIST_MAX       = (1 << DIST_W) - 1;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned PRINT_CAP      = 40;

  typedef logic signed [COORD_FIELD_W-1:0] coord_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_t                   in_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_t                  out_o;

  // Shared idling controls of the sender and the receiver.
  bit calm;
  bit hold_request;

  pairwise_distance_and_radius_unit #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .MAX_DIMENSIONS(MAX_DIMENSIONS),
    .COORD_WIDTH   (COORD_FIELD_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  // Scoreboard: keeps its own copy of the position store, the set counter
  // and both registers, and queues the distances each particle must produce.
  class distance_scoreboard;
    coord_t      positions [MAX_PARTICLES][MAX_DIMENSIONS];
    int unsigned next_index;
    int unsigned dims_reg;
    int unsigned parts_reg;
    out_t        pending_distances[$];
    int          errors;

    function new();
      foreach (positions[i, d]) positions[i][d] = '0;
      next_index = 0;
      dims_reg   = DIMS_RESET;
      parts_reg  = PARTS_RESET;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_DIMS_IN_USE) begin
        dims_reg = value[1:0];
      end else if (idx == REG_PARTICLES_IN_USE) begin
        parts_reg = value;
      end
    endfunction

    function int pending();
      return pending_distances.size();
    endfunction

    // Floored Euclidean distance over the first nd coordinates.
    function logic [DIST_W-1:0] separation(coord_t p[MAX_DIMENSIONS],
                                           coord_t q[MAX_DIMENSIONS],
                                           int unsigned nd);
      longint unsigned acc;
      longint unsigned cand;
      longint unsigned root;
      longint          diff;
      acc  = 0;
      root = 0;
      for (int d = 0; d < nd; d++) begin
        diff = longint'(p[d]) - longint'(q[d]);
        if (diff < 0) diff = -diff;
        acc += longint'(diff * diff);
      end
      // Build the root one bit at a time from the top.
      for (int b = DIST_W; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= acc) root = cand;
      end
      if (root > DIST_MAX) root = DIST_MAX;
      return root[DIST_W-1:0];
    endfunction

    // Stores the accepted particle and queues its radial and pair results.
    function void note_particle(in_t item);
      coord_t      origin [MAX_DIMENSIONS];
      coord_t      here [MAX_DIMENSIONS];
      int unsigned nd;
      int unsigned np;
      int unsigned k;
      out_t        res;
      foreach (origin[d]) origin[d] = '0;
      nd = (dims_reg < 1) ? 1 : (dims_reg > MAX_DIMENSIONS) ? MAX_DIMENSIONS : dims_reg;
      np = (parts_reg < 1) ? 1 : (parts_reg > MAX_PARTICLES) ? MAX_PARTICLES : parts_reg;
      if (item.new_set) next_index = 0;
      k = next_index;
      // A count left beyond a lowered set size starts a fresh set.
      if (k >= np) k = 0;
      positions[k][0] = item.coord_x;
      positions[k][1] = item.coord_y;
      positions[k][2] = item.coord_z;
      here = positions[k];

      res.kind         = KIND_RADIAL;
      res.first_index  = k[IDX_OUT_W-1:0];
      res.second_index = k[IDX_OUT_W-1:0];
      res.distance     = separation(here, origin, nd);
      res.last         = (k == 0);
      pending_distances.push_back(res);
      for (int unsigned j = 0; j < k; j++) begin
        res.kind         = KIND_PAIR;
        res.first_index  = j[IDX_OUT_W-1:0];
        res.second_index = k[IDX_OUT_W-1:0];
        res.distance     = separation(here, positions[j], nd);
        res.last         = (j + 1 == k);
        pending_distances.push_back(res);
      end

      k++;
      if (k >= np) k = 0;
      next_index = k;
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (pending_distances.size() == 0) begin
        report($sformatf("unexpected result %p", got));
      end else begin
        want = pending_distances.pop_front();
        if (got.kind !== want.kind)
          report($sformatf("kind %0b, expected %0b", got.kind, want.kind));
        if (got.first_index !== want.first_index)
          report($sformatf("first_index %0d, expected %0d",
                           got.first_index, want.first_index));
        if (got.second_index !== want.second_index)
          report($sformatf("second_index %0d, expected %0d",
                           got.second_index, want.second_index));
        if (got.distance !== want.distance)
          report($sformatf("distance %0d, expected %0d (pair %0d-%0d)",
                           got.distance, want.distance,
                           want.first_index, want.second_index));
        if (got.last !== want.last)
          report($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    endtask
  endclass

  distance_scoreboard matrix_sb = new();

  // Clock: 2 ns period.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic coord_t random_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'sh8000;
    if (r < 10) return 16'sh7fff;
    if (r < 13) return '0;
    if (r < 15) return '1;
    return coord_t'($urandom);
  endfunction

  function automatic in_t random_particle();
    in_t p;
    p.coord_x = random_coord();
    p.coord_y = random_coord();
    p.coord_z = random_coord();
    // Occasional restarts break sets off early.
    p.new_set = ($urandom_range(0, 99) < 7);
    return p;
  endfunction

  // Offers one particle and holds it until the block takes the transaction.
  task automatic offer_particle(input in_t item);
    int idle;
    idle = calm ? 0 : idle_cycles();
    if (idle > 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    matrix_sb.note_particle(item);
  endtask

  task automatic place(input int x, input int y, input int z, input bit fresh);
    in_t p;
    p.coord_x = x[COORD_FIELD_W-1:0];
    p.coord_y = y[COORD_FIELD_W-1:0];
    p.coord_z = z[COORD_FIELD_W-1:0];
    p.new_set = fresh;
    offer_particle(p);
  endtask

  // Waits until every expected result has come out, then lets the pipeline
  // settle before both registers are written.
  task automatic configure(input logic [1:0] dims, input logic [3:0] parts);
    in_valid_i <= 1'b0;
    while (matrix_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_DIMS_IN_USE;
    cfg_data_i <= {2'b00, dims};
    @(posedge clk_i);
    matrix_sb.set_reg(REG_DIMS_IN_USE, {2'b00, dims});
    cfg_idx_i  <= REG_PARTICLES_IN_USE;
    cfg_data_i <= parts;
    @(posedge clk_i);
    matrix_sb.set_reg(REG_PARTICLES_IN_USE, parts);
    cfg_we_i <= 1'b0;
  endtask

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) matrix_sb.check_result(out_o);
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin : receiver
    int idle;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        idle = calm ? 0 : idle_cycles();
        if (idle > 0) begin
          out_ready_i <= 1'b0;
          repeat (idle) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Stimulus.
  initial begin : stimulus
    logic [1:0] dims_pick;
    logic [3:0] parts_pick;
    calm         = 1'b0;
    hold_request = 1'b0;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= REG_DIMS_IN_USE;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    in_i         <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full three-dimensional set of eight with the coordinate extremes,
    // then a wrap to index zero and a restart in the middle of a set.
    configure(2'd3, 4'd8);
    place(-32768, -32768, -32768, 1'b1);
    place(32767, 32767, 32767, 1'b0);
    place(0, 0, 0, 1'b0);
    place(32767, -32768, 0, 1'b0);
    place(-1, 1, -32768, 1'b0);
    place(4096, -4096, 2048, 1'b0);
    place(12345, -23456, 31000, 1'b0);
    place(-20000, 100, 5, 1'b0);
    place(1, 2, 3, 1'b0);
    place(7, 7, 7, 1'b0);
    place(100, 200, 300, 1'b1);
    place(-100, -200, -300, 1'b0);
    place(5, 5, 5, 1'b0);

    // Zero dimensions act as one; a set size below the current count
    // restarts the set, and a size of two wraps quickly.
    configure(2'd0, 4'd2);
    place(-32768, 32767, 32767, 1'b0);
    place(32767, -32768, -32768, 1'b0);
    place(-300, 999, -999, 1'b0);

    // A set size of zero acts as one: every particle is index zero.
    configure(2'd1, 4'd0);
    place(-32768, 5, 5, 1'b0);
    place(32767, 5, 5, 1'b0);
    place(-5, 5, 5, 1'b1);

    // Two dimensions, oversized set size acting as the maximum.
    configure(2'd2, 4'd15);
    place(3000, -4000, 32767, 1'b1);
    place(-3000, 4000, -32768, 1'b0);
    place(32767, 32767, 0, 1'b0);
    place(-32768, -32768, 0, 1'b0);
    place(0, -1, 0, 1'b0);

    // Random phases with varying register settings. The first one asks the
    // receiver for a long hold-off while particles keep coming, the third
    // runs without idling on either side.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        dims_pick  = 2'd3;
        parts_pick = 4'd8;
      end else if (ph == 1) begin
        dims_pick  = 2'd1;
        parts_pick = 4'd15;
      end else begin
        dims_pick  = 2'($urandom_range(0, 3));
        parts_pick = ($urandom_range(0, 99) < 70) ? 4'($urandom_range(5, 15))
                                                  : 4'($urandom_range(0, 4));
      end
      configure(dims_pick, parts_pick);
      calm = (ph == 2);
      for (int n = 0; n < 15; n++) begin
        if (ph == 0 && n == 4) hold_request = 1'b1;
        offer_particle(random_particle());
      end
      calm = 1'b0;
    end

    // Drain and give stray results time to show up.
    in_valid_i <= 1'b0;
    while (matrix_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (matrix_sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog.
  initial begin : watchdog
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
